// ===== rtl/rtt_pkg.sv =====
// Package for the radix text to integer block.
// Holds character codes, radix limits and the decoded-character struct.
// No dependencies.
package rtt_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitW = 6;
  localparam int unsigned RadixW = 6;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  // Radix register limits and reset value
  localparam logic [RadixW-1:0] RADIX_RESET = 6'd10;
  localparam logic [RadixW-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RadixW-1:0] RADIX_MAX   = 6'd36;

  // Register index of the radix register
  localparam logic REG_RADIX = 1'b0;

  // ASCII codes
  localparam logic [CharW-1:0] CHAR_MINUS   = 8'd45;
  localparam logic [CharW-1:0] CHAR_NUM_LO  = 8'd48;
  localparam logic [CharW-1:0] CHAR_NUM_HI  = 8'd57;
  localparam logic [CharW-1:0] CHAR_UPR_LO  = 8'd65;
  localparam logic [CharW-1:0] CHAR_UPR_HI  = 8'd90;
  localparam logic [CharW-1:0] CHAR_LWR_LO  = 8'd97;
  localparam logic [CharW-1:0] CHAR_LWR_HI  = 8'd122;
  localparam logic [CharW-1:0] OFFS_NUM     = 8'd48;
  localparam logic [CharW-1:0] OFFS_UPR     = 8'd55;
  localparam logic [CharW-1:0] OFFS_LWR     = 8'd87;

  // One decoded character
  typedef struct packed {
    logic              minus;  // character is '-'
    logic              alnum;  // character is 0-9, a-z or A-Z
    logic [DigitW-1:0] digit;  // digit value 0..35 when alnum
  } dec_t;

endpackage

// ===== rtl/rtt_char_decode.sv =====
// Character decoder: maps an ASCII code to a digit value and class flags.
// Depends on rtt_pkg.
module rtt_char_decode (
  input  logic [rtt_pkg::CharW-1:0] char_code_i,
  output rtt_pkg::dec_t             dec_o
);
  import rtt_pkg::*;

  logic              is_num;
  logic              is_upr;
  logic              is_lwr;
  logic [CharW-1:0]  offs;
  logic [CharW-1:0]  diff;

  // Class ranges
  assign is_num = (char_code_i >= CHAR_NUM_LO) && (char_code_i <= CHAR_NUM_HI);
  assign is_upr = (char_code_i >= CHAR_UPR_LO) && (char_code_i <= CHAR_UPR_HI);
  assign is_lwr = (char_code_i >= CHAR_LWR_LO) && (char_code_i <= CHAR_LWR_HI);

  // Offset for the matching class
  always_comb begin
    priority if (is_lwr) begin
      offs = OFFS_LWR;
    end else if (is_upr) begin
      offs = OFFS_UPR;
    end else begin
      offs = OFFS_NUM;
    end
  end

  assign diff = char_code_i - offs;

  assign dec_o.minus = (char_code_i == CHAR_MINUS);
  assign dec_o.alnum = is_num || is_upr || is_lwr;
  assign dec_o.digit = diff[DigitW-1:0];

endmodule

// ===== rtl/rtt_accum.sv =====
// Accumulator stage: string state, multiply-accumulate and result register.
// Depends on rtt_pkg.
module rtt_accum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       last_i,
  input  rtt_pkg::dec_t              dec_i,
  input  logic [rtt_pkg::RadixW-1:0] radix_i,
  output logic                       advance_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rtt_pkg::ValueW-1:0] value_o,
  output logic                       bad_digit_o
);
  import rtt_pkg::*;

  logic              first_q;
  logic              neg_q;
  logic              err_q;
  logic [ValueW-1:0] acc_q;
  logic              out_valid_q;
  logic [ValueW-1:0] value_q;
  logic              bad_q;

  logic              take_sign;
  logic              bad_char;
  logic              neg_d;
  logic              err_d;
  logic [ValueW-1:0] prod;
  logic [ValueW-1:0] acc_d;

  // The item moves on unless it is the last and the result slot is full and not read
  assign advance_o = valid_i && (!last_i || !out_valid_q || out_ready_i);

  assign take_sign = first_q && dec_i.minus;
  assign bad_char  = !dec_i.alnum || (radix_i < RADIX_MIN) || (radix_i > RADIX_MAX)
                     || (dec_i.digit >= radix_i);

  // Accumulator holds the signed value: a negative string subtracts digits
  assign prod = acc_q * ValueW'(radix_i);

  always_comb begin
    neg_d = neg_q;
    err_d = err_q;
    acc_d = acc_q;
    if (take_sign) begin
      neg_d = 1'b1;
    end else if (bad_char) begin
      err_d = 1'b1;
    end else if (neg_q) begin
      acc_d = prod - ValueW'(dec_i.digit);
    end else begin
      acc_d = prod + ValueW'(dec_i.digit);
    end
  end

  // String state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
      acc_q   <= '0;
    end else if (advance_o) begin
      first_q <= last_i;
      if (last_i) begin
        neg_q <= 1'b0;
        err_q <= 1'b0;
        acc_q <= '0;
      end else begin
        neg_q <= neg_d;
        err_q <= err_d;
        acc_q <= acc_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o && last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && last_i) begin
      value_q <= err_d ? '0 : acc_d;
      bad_q   <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign bad_digit_o = bad_q;

endmodule

// ===== rtl/radix_text_to_integer.sv =====
// Radix text to integer, top level.
// Last character: input register, then result register, which drives the outputs.
// Throughput: one character per cycle while results are taken; 64x6 multiply-accumulate sets the path.
// Reset: radix returns to 10, the string state to start of string, no result pending.
// Depends on rtt_pkg, rtt_char_decode, rtt_accum.
module radix_text_to_integer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rtt_pkg::AddrW-1:0]   paddr,
  input  logic [rtt_pkg::DataW-1:0]   pwdata,
  output logic [rtt_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  // Character input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rtt_pkg::CharW-1:0]   char_code_i,
  input  logic                        is_last_i,
  // Result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [rtt_pkg::ValueW-1:0] value_o,
  output logic                        bad_digit_o
);
  import rtt_pkg::*;

  logic [RadixW-1:0] radix_q;
  logic              in_valid_q;
  logic              last_q;
  dec_t              dec_q;
  dec_t              dec;
  logic              advance;
  logic              in_take;
  logic [ValueW-1:0] value;

  // Radix register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIX) ? DataW'(radix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RADIX)) begin
      radix_q <= pwdata[RadixW-1:0];
    end
  end

  // Decode ahead of the input register
  rtt_char_decode u_decode (
    .char_code_i (char_code_i),
    .dec_o       (dec)
  );

  // Input register
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      last_q <= is_last_i;
      dec_q  <= dec;
    end
  end

  rtt_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_q),
    .last_i      (last_q),
    .dec_i       (dec_q),
    .radix_i     (radix_q),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value),
    .bad_digit_o (bad_digit_o)
  );

  assign value_o = value;

endmodule

// ===== tb/sv/radix_text_to_integer_tb.sv =====
// Testbench for radix_text_to_integer: a directed table of strings, then random strings.
// It checks each result against a parser model in this file and reads the radix back.
// Depends on rtt_pkg and the radix_text_to_integer RTL.
module radix_text_to_integer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtt_pkg::*;

  localparam logic [AddrW-1:0] ADDR_RADIX  = {REG_RADIX, 2'b00};
  localparam logic [AddrW-1:0] ADDR_UNUSED = {~REG_RADIX, 2'b00};
  localparam logic [7:0]       NOT_DIGIT   = 8'hFF;
  localparam int unsigned      NUM_CHARS   = 1500;
  localparam int unsigned      DRAIN_CYC   = 4;

  // DUT ports
  logic                    clk_i, rst_ni;
  logic                    psel, penable, pwrite, pready;
  logic [AddrW-1:0]        paddr;
  logic [DataW-1:0]        pwdata, prdata;
  logic                    in_valid_i, in_ready_o, is_last_i;
  logic [CharW-1:0]        char_code_i;
  logic                    out_valid_o, out_ready_i, bad_digit_o;
  logic signed [ValueW-1:0] value_o;

  // One parsed number as the block should return it
  typedef struct {
    logic [ValueW-1:0] val;
    logic              bad;
  } parse_res_t;

  // One row of the directed table: a register write or a character
  typedef struct {
    bit                cfg;
    logic [AddrW-1:0]  addr;
    logic [DataW-1:0]  data;
    logic [CharW-1:0]  chr;
    logic              last;
    bit                known;
    logic [ValueW-1:0] val;
    logic              bad;
  } text_row_t;

  parse_res_t parsed_q[$];
  parse_res_t head;
  text_row_t  text_rows[$];
  int unsigned err_cnt;
  int unsigned chars_sent;
  bit          no_idle;
  int unsigned ready_stall;

  // Parser model state
  logic [RadixW-1:0] radix_q;
  logic [ValueW-1:0] acc_q;
  logic              neg_q, first_q, err_q;

  radix_text_to_integer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .bad_digit_o (bad_digit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // Mostly short gaps, a few long ones, none during quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  // Digit value of a character, NOT_DIGIT if not alphanumeric
  function automatic logic [7:0] digit_val(input logic [CharW-1:0] c);
    if (c >= CHAR_LWR_LO && c <= CHAR_LWR_HI) return c - OFFS_LWR;
    if (c >= CHAR_UPR_LO && c <= CHAR_UPR_HI) return c - OFFS_UPR;
    if (c >= CHAR_NUM_LO && c <= CHAR_NUM_HI) return c - OFFS_NUM;
    return NOT_DIGIT;
  endfunction

  function automatic logic [CharW-1:0] digit_char(input int unsigned d, input bit upper);
    if (d < 10) return CharW'(CHAR_NUM_LO + d);
    return upper ? CharW'(OFFS_UPR + d) : CharW'(OFFS_LWR + d);
  endfunction

  function automatic void clear_text();
    acc_q   = '0;
    neg_q   = 1'b0;
    first_q = 1'b1;
    err_q   = 1'b0;
  endfunction

  // Advance the parser by one character; returns 1 when a number is complete
  function automatic bit parse_char(input logic [CharW-1:0] c, input logic last,
                                    output logic [ValueW-1:0] v, output logic b);
    logic [7:0] d;
    bit         was_first;
    was_first = first_q;
    first_q   = 1'b0;
    if (was_first && c == CHAR_MINUS) begin
      neg_q = 1'b1;
    end else begin
      d = digit_val(c);
      if (radix_q < RADIX_MIN || radix_q > RADIX_MAX || d >= {2'b00, radix_q}) begin
        err_q = 1'b1;
      end else begin
        acc_q = acc_q * {58'd0, radix_q} + {56'd0, d};
      end
    end
    b = err_q;
    v = err_q ? '0 : (neg_q ? -acc_q : acc_q);
    if (last) clear_text();
    return last;
  endfunction

  // Present one character and hold it until taken
  task automatic send_char(input logic [CharW-1:0] c, input logic last, input bit known,
                           input logic [ValueW-1:0] kval, input logic kbad);
    parse_res_t res;
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    char_code_i = c;
    is_last_i   = last;
    do @(posedge clk_i); while (!in_ready_o);
    if (parse_char(c, last, res.val, res.bad)) begin
      if (known) begin
        res.val = kval;
        res.bad = kbad;
      end
      parsed_q.push_back(res);
    end
    chars_sent++;
  endtask

  task automatic idle_in(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i  = 1'b0;
      char_code_i = CharW'($urandom);
      is_last_i   = 1'($urandom);
    end
  endtask

  // Register write once the pipeline has drained, then read the radix back
  task automatic write_radix(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[AddrW-1:2] == REG_RADIX) radix_q = data[RadixW-1:0];
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_RADIX;
    pwdata  = $urandom;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(DataW-RadixW){1'b0}}, radix_q})
      report($sformatf("radix readback: expected %0d, got %0d", radix_q, prdata));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Directed table builders
  function automatic void add_char(input logic [CharW-1:0] c, input logic last);
    text_rows.push_back('{cfg: 1'b0, addr: '0, data: '0, chr: c, last: last, known: 1'b0,
                          val: '0, bad: 1'b0});
  endfunction

  function automatic void add_known(input logic [CharW-1:0] c, input logic [ValueW-1:0] v,
                                    input logic b);
    text_rows.push_back('{cfg: 1'b0, addr: '0, data: '0, chr: c, last: 1'b1, known: 1'b1,
                          val: v, bad: b});
  endfunction

  function automatic void add_cfg(input logic [AddrW-1:0] a, input logic [DataW-1:0] d);
    text_rows.push_back('{cfg: 1'b1, addr: a, data: d, chr: '0, last: 1'b0, known: 1'b0,
                          val: '0, bad: 1'b0});
  endfunction

  // New radix: mostly legal, sometimes the limits, rarely out of range
  task automatic random_radix();
    logic [RadixW-1:0] r;
    int unsigned       pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)      r = RadixW'($urandom_range(0, 1));
    else if (pick == 1) r = RadixW'($urandom_range(37, 63));
    else if (pick < 5)  r = ($urandom_range(0, 1) != 0) ? RADIX_MIN : RADIX_MAX;
    else                r = RadixW'($urandom_range(2, 36));
    write_radix(($urandom_range(0, 9) == 0) ? ADDR_UNUSED : ADDR_RADIX,
                {26'($urandom), r});
  endtask

  // One random string: mostly well-formed, some with a bad character, some noise
  task automatic random_string();
    int unsigned       len, kind, pick, max_d;
    int                bad_pos;
    logic [CharW-1:0]  c;
    pick = $urandom_range(0, 9);
    len  = (pick < 7) ? $urandom_range(1, 6) :
           (pick < 9) ? $urandom_range(7, 14) : $urandom_range(15, 24);
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      // lone minus
      send_char(CHAR_MINUS, 1'b1, 1'b0, '0, 1'b0);
      idle_in(pick_gap());
      return;
    end
    if (kind >= 4 && kind < 30 && $urandom_range(0, 3) == 0) begin
      send_char(CHAR_MINUS, 1'b0, 1'b0, '0, 1'b0);
      idle_in(pick_gap());
    end
    bad_pos = (kind >= 84) ? int'($urandom_range(0, len - 1)) : -1;
    max_d   = (radix_q >= RADIX_MIN && radix_q <= RADIX_MAX) ? radix_q - 1 : 35;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 49) == 0) random_radix();
      if (kind >= 30 && kind < 34) begin
        c = CharW'($urandom_range(0, 255));
      end else if (i == bad_pos) begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          c = CHAR_MINUS;
        end else if (pick == 1 && max_d < 35) begin
          c = digit_char($urandom_range(max_d + 1, 35), 1'($urandom_range(0, 1)));
        end else begin
          do c = CharW'($urandom_range(0, 255)); while (digit_val(c) != NOT_DIGIT);
        end
      end else begin
        c = digit_char($urandom_range(0, max_d), 1'($urandom_range(0, 1)));
      end
      send_char(c, i == len - 1, 1'b0, '0, 1'b0);
      idle_in(pick_gap());
    end
  endtask

  // Result receiver with random stalls
  initial begin
    out_ready_i = 1'b0;
    ready_stall = 0;
    forever begin
      @(negedge clk_i);
      if (ready_stall > 0) begin
        out_ready_i = 1'b0;
        ready_stall--;
      end else begin
        out_ready_i = 1'b1;
        ready_stall = pick_gap();
      end
    end
  end

  // Compare each taken result with the oldest expected number
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parsed_q.size() == 0) begin
        report($sformatf("unexpected result: value %0d bad_digit %0b", value_o, bad_digit_o));
      end else begin
        head = parsed_q.pop_front();
        if (value_o !== head.val || bad_digit_o !== head.bad)
          report($sformatf("result mismatch: expected %0d/%0b, got %0d/%0b",
                           $signed(head.val), head.bad, value_o, bad_digit_o));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    is_last_i   = 1'b0;
    err_cnt     = 0;
    chars_sent  = 0;
    no_idle     = 1'b0;
    radix_q     = RADIX_RESET;
    clear_text();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset radix, sign handling, bad characters, radix limits
    add_known("7", 64'd7, 1'b0);
    add_known(CHAR_MINUS, '0, 1'b0);
    add_char(CHAR_MINUS, 1'b0);
    add_char("1", 1'b0);
    add_known("2", -64'd12, 1'b0);
    add_char("1", 1'b0);
    add_char(CHAR_MINUS, 1'b0);
    add_known("3", '0, 1'b1);
    add_known("A", '0, 1'b1);
    add_known(8'hFF, '0, 1'b1);
    add_known(8'h00, '0, 1'b1);
    add_cfg(ADDR_RADIX, DataW'(RADIX_MAX));
    add_char("z", 1'b0);
    add_char("Z", 1'b0);
    add_char("a", 1'b1);
    add_cfg(ADDR_RADIX, DataW'(RADIX_MIN));
    add_char("1", 1'b0);
    add_char("0", 1'b0);
    add_known("1", 64'd5, 1'b0);
    add_known("2", '0, 1'b1);
    add_cfg(ADDR_RADIX, 32'd0);
    add_known("0", '0, 1'b1);
    add_cfg(ADDR_RADIX, 32'd63);
    add_known("1", '0, 1'b1);
    add_cfg(ADDR_RADIX, 32'd1);
    add_known("0", '0, 1'b1);
    add_cfg(ADDR_RADIX, 32'd37);
    add_known("0", '0, 1'b1);
    // radix changes in the middle of a string
    add_cfg(ADDR_RADIX, 32'd10);
    add_char("4", 1'b0);
    add_cfg(ADDR_RADIX, 32'd16);
    add_char("f", 1'b1);
    // upper write bits dropped, other address ignored
    add_cfg(ADDR_RADIX, 32'hFFFF_FFE4);
    add_cfg(ADDR_UNUSED, 32'd2);
    add_char(CHAR_MINUS, 1'b0);
    add_char("z", 1'b1);

    foreach (text_rows[i]) begin
      if (text_rows[i].cfg) begin
        write_radix(text_rows[i].addr, text_rows[i].data);
      end else begin
        send_char(text_rows[i].chr, text_rows[i].last, text_rows[i].known,
                  text_rows[i].val, text_rows[i].bad);
        idle_in(pick_gap());
      end
    end

    // Random strings, with occasional radix changes and quiet stretches
    while (chars_sent < NUM_CHARS) begin
      if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 11) == 0) random_radix();
      random_string();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rtt_pkg.sv
rtl/rtt_char_decode.sv
rtl/rtt_accum.sv
rtl/radix_text_to_integer.sv
tb/sv/radix_text_to_integer_tb.sv
